// ===== rtl/bac_pkg.sv =====
// Shared types and constants for the banded anchor chaining core.
// Used by the channel interfaces, the window memory, the scan engine and the top level.
// Depends on nothing.
package bac_pkg;

    localparam int TARGET_W   = 31;
    localparam int QUERY_W    = 31;
    localparam int SCORE_W    = 32;
    localparam int INDEX_W    = 20;
    localparam int COUNT_W    = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Anchors at or beyond this group index are flagged as overflow.
    localparam logic [COUNT_W-1:0] MAX_GROUP = 32'd1048576;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_WEIGHT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GAP        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TARGET_GAP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_LENGTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SKIPS      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SCORE      = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [7:0]  SEED_WEIGHT_RST    = 8'd6;
    localparam logic [15:0] MAX_GAP_RST        = 16'd500;
    localparam logic [15:0] MAX_TARGET_GAP_RST = 16'd5000;
    localparam logic [6:0]  BAND_LENGTH_RST    = 7'd64;
    localparam logic [7:0]  MAX_SKIPS_RST      = 8'd25;
    localparam logic [15:0] MIN_SCORE_RST      = 16'd15;

    typedef struct packed {
        logic [7:0]  seed_weight;
        logic [15:0] max_gap;
        logic [15:0] max_target_gap;
        logic [6:0]  band_length;
        logic [7:0]  max_skips;
        logic [15:0] min_score;
    } cfg_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [QUERY_W-1:0]  query;
        logic [SCORE_W-1:0]  score;
    } window_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/bac_if.sv =====
// Valid/ready channel interfaces: anchor input, chaining result output, config writes.
// Depends on bac_pkg for field widths.
interface bac_anchor_if;
    logic                          valid;
    logic                          ready;
    logic [bac_pkg::TARGET_W-1:0]  target_coord;
    logic [bac_pkg::QUERY_W-1:0]   query_coord;
    logic                          group_start;
    logic                          read_start;

    modport source (output valid, output target_coord, output query_coord,
                    output group_start, output read_start, input ready);
    modport sink   (input valid, input target_coord, input query_coord,
                    input group_start, input read_start, output ready);
endinterface

interface bac_result_if;
    logic                         valid;
    logic                         ready;
    logic [bac_pkg::SCORE_W-1:0]  chain_score;
    logic [bac_pkg::INDEX_W-1:0]  predecessor_index;
    logic [bac_pkg::INDEX_W-1:0]  group_index;
    logic                         end_candidate;
    logic                         overflow;

    modport source (output valid, output chain_score, output predecessor_index,
                    output group_index, output end_candidate, output overflow,
                    input ready);
    modport sink   (input valid, input chain_score, input predecessor_index,
                    input group_index, input end_candidate, input overflow,
                    output ready);
endinterface

interface bac_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bac_pkg::CFG_INDEX_W-1:0] index;
    logic [bac_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/banded_anchor_chaining_dp_core.sv =====
// Banded anchor chaining core: configuration registers and the chaining engine.
// Usage: anchors enter on the anchors channel, one result per anchor leaves on
//   the results channel, and registers are written on the cfg channel, which is
//   always ready and must only be used while the core is idle.
// Per anchor the engine scans back over L = min(band_length, BAND, anchors
//   already seen in the group) window entries, reading one entry of the window
//   memory per cycle through a three-stage compare pipeline. The scan runs to the
//   end (it is skipped when L is zero) unless a target-gap break or the skip
//   limit ends it early. One anchor is in work at a time, so the next anchor is
//   taken in the cycle after the previous result is loaded into the output register.
// The output register holds a finished result while the receiver stalls; the
//   core still takes the next anchor and scans it, and waits before its own
//   result load until the register is free.
// Reset restores the register defaults, clears the group index, the window fill
//   and the running maximum; the window memory is not cleared and needs no pass.
module banded_anchor_chaining_dp_core #(
    parameter int BAND = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    bac_anchor_if.sink    anchors,
    bac_result_if.source  results,
    bac_cfg_if.sink       cfg
);

    bac_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed_weight    <= bac_pkg::SEED_WEIGHT_RST;
            cfg_reg.max_gap        <= bac_pkg::MAX_GAP_RST;
            cfg_reg.max_target_gap <= bac_pkg::MAX_TARGET_GAP_RST;
            cfg_reg.band_length    <= bac_pkg::BAND_LENGTH_RST;
            cfg_reg.max_skips      <= bac_pkg::MAX_SKIPS_RST;
            cfg_reg.min_score      <= bac_pkg::MIN_SCORE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bac_pkg::CFG_SEED_WEIGHT:    cfg_reg.seed_weight    <= cfg.data[7:0];
                bac_pkg::CFG_MAX_GAP:        cfg_reg.max_gap        <= cfg.data;
                bac_pkg::CFG_MAX_TARGET_GAP: cfg_reg.max_target_gap <= cfg.data;
                bac_pkg::CFG_BAND_LENGTH:    cfg_reg.band_length    <= cfg.data[6:0];
                bac_pkg::CFG_MAX_SKIPS:      cfg_reg.max_skips      <= cfg.data[7:0];
                bac_pkg::CFG_MIN_SCORE:      cfg_reg.min_score      <= cfg.data;
                default:                     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    bac_scan #(
        .BAND (BAND)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .anchors (anchors),
        .results (results)
    );

endmodule

// ===== rtl/bac_window.sv =====
// Anchor window memory: one write port, one read port with registered read data.
// Depends on bac_pkg for the entry type.
module bac_window #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  bac_pkg::window_entry_t wentry,
    input  logic [AW-1:0]          raddr,
    output bac_pkg::window_entry_t rentry
);

    bac_pkg::window_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wentry;
        end
    end

    always_ff @(posedge clk)
    begin
        rentry <= mem[raddr];
    end

endmodule

// ===== rtl/bac_scan.sv =====
// Chaining engine: control FSM, backward scan pipeline over the anchor window,
// group/read bookkeeping and the result output register.
// Depends on bac_pkg, bac_if and bac_window.
module bac_scan #(
    parameter int BAND = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bac_pkg::cfg_t        cfg,
    bac_anchor_if.sink           anchors,
    bac_result_if.source         results
);

    localparam int AW  = (BAND > 1) ? $clog2(BAND) : 1;
    localparam int CW  = $clog2(BAND + 1);
    localparam int LW  = (CW > 7) ? CW : 7;
    localparam int SKW = ((CW > 8) ? CW : 8) + 2;
    localparam logic [AW-1:0] LAST_ADDR = AW'(BAND - 1);
    localparam logic [CW-1:0] BAND_C    = CW'(BAND);

    bac_pkg::state_t state_reg, state_next;

    logic [bac_pkg::TARGET_W-1:0] tq_reg;
    logic [bac_pkg::QUERY_W-1:0]  qq_reg;
    logic [CW-1:0]                lim_reg;
    logic [CW-1:0]                issue_cnt_reg;
    logic [AW-1:0]                rd_ptr_reg;

    logic                         p0_v_reg;
    logic [CW-1:0]                p0_k_reg;

    logic                         s1_v_reg, s1_pass_reg, s1_brk_reg;
    logic signed [31:0]           s1_dt_reg, s1_dq_reg;
    logic [bac_pkg::SCORE_W-1:0]  s1_ps_reg;
    logic [CW-1:0]                s1_k_reg;

    logic                         s2_v_reg, s2_pass_reg, s2_brk_reg, s2_link_reg;
    logic [7:0]                   s2_m_reg;
    logic [bac_pkg::SCORE_W-1:0]  s2_ps_reg;
    logic [CW-1:0]                s2_k_reg;

    logic [bac_pkg::SCORE_W-1:0]  score_reg;
    logic [CW-1:0]                best_k_reg;
    logic signed [SKW-1:0]        skips_reg;

    logic [AW-1:0]                wr_ptr_reg;
    logic [CW-1:0]                fill_reg;
    logic [bac_pkg::COUNT_W-1:0]  group_count_reg;
    logic [bac_pkg::SCORE_W-1:0]  running_best_reg;

    logic                         out_valid_reg;
    logic [bac_pkg::SCORE_W-1:0]  out_score_reg;
    logic [bac_pkg::INDEX_W-1:0]  out_pred_reg;
    logic [bac_pkg::INDEX_W-1:0]  out_index_reg;
    logic                         out_end_reg;
    logic                         out_ovf_reg;

    bac_pkg::window_entry_t       wentry, rentry;
    logic [AW-1:0]                raddr;

    logic in_ready, commit, scan_active;
    logic accept, group_reset, out_free;
    logic [CW-1:0] fill_eff, lim_next;
    logic [LW-1:0] lim_a, lim_b;
    logic issue, stop_now;

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bac_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (lim_next == '0) ? bac_pkg::ST_DONE : bac_pkg::ST_SCAN;
                end
            end
            bac_pkg::ST_SCAN:
            begin
                if (stop_now)
                begin
                    state_next = bac_pkg::ST_DONE;
                end
            end
            bac_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = bac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bac_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        scan_active = 1'b0;
        commit      = 1'b0;
        unique case (state_reg)
            bac_pkg::ST_IDLE: in_ready    = 1'b1;
            bac_pkg::ST_SCAN: scan_active = 1'b1;
            bac_pkg::ST_DONE: commit      = out_free;
            default:          in_ready    = 1'b0;
        endcase
    end

    assign anchors.ready = in_ready;
    assign accept        = anchors.valid && in_ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign group_reset   = anchors.group_start || anchors.read_start;

    // Scan length is the smallest of band_length, BAND and the window fill.
    assign fill_eff = group_reset ? '0 : fill_reg;
    always_comb
    begin
        lim_a = (LW'(cfg.band_length) < LW'(BAND_C)) ? LW'(cfg.band_length) : LW'(BAND_C);
        lim_b = (lim_a < LW'(fill_eff)) ? lim_a : LW'(fill_eff);
    end
    assign lim_next = lim_b[CW-1:0];

    // ---------------------------------------------------------------- reads
    assign raddr = (rd_ptr_reg == '0) ? LAST_ADDR : rd_ptr_reg - 1'b1;
    assign issue = scan_active && !stop_now && (issue_cnt_reg != lim_reg);

    assign wentry.target = tq_reg;
    assign wentry.query  = qq_reg;
    assign wentry.score  = score_reg;

    bac_window #(
        .DEPTH (BAND),
        .AW    (AW)
    ) u_window (
        .clk    (clk),
        .we     (commit),
        .waddr  (wr_ptr_reg),
        .wentry (wentry),
        .raddr  (raddr),
        .rentry (rentry)
    );

    // ---------------------------------------------------------------- stage 1
    logic                     s1_eq, s1_brk_c, s1_neg;
    logic [31:0]              s1_reach;
    logic signed [31:0]       s1_dt_c, s1_dq_c;

    always_comb
    begin
        s1_eq    = (rentry.query == qq_reg) || (rentry.target == tq_reg);
        s1_reach = {1'b0, rentry.target} + {16'd0, cfg.max_target_gap};
        s1_brk_c = s1_reach < {1'b0, tq_reg};
        s1_dt_c  = $signed({1'b0, tq_reg}) - $signed({1'b0, rentry.target});
        s1_dq_c  = $signed({1'b0, qq_reg}) - $signed({1'b0, rentry.query});
        s1_neg   = s1_dq_c[31];
    end

    // ---------------------------------------------------------------- stage 2
    logic signed [32:0]       gap_diff;
    logic [32:0]              gap_abs;
    logic signed [34:0]       dt35, dq35, five_dt, three_dt, four_dq;
    logic signed [31:0]       dmin, sw_s;
    logic                     link_c;
    logic [7:0]               m_c;

    always_comb
    begin
        gap_diff = {s1_dt_reg[31], s1_dt_reg} - {s1_dq_reg[31], s1_dq_reg};
        gap_abs  = gap_diff[32] ? 33'(-gap_diff) : 33'(gap_diff);
        dt35     = {{3{s1_dt_reg[31]}}, s1_dt_reg};
        dq35     = {{3{s1_dq_reg[31]}}, s1_dq_reg};
        five_dt  = (dt35 <<< 2) + dt35;
        three_dt = (dt35 <<< 1) + dt35;
        four_dq  = dq35 <<< 2;
        link_c   = (gap_abs < {17'd0, cfg.max_gap}) && (dq35 < five_dt) && (four_dq > three_dt);
        dmin     = (s1_dt_reg < s1_dq_reg) ? s1_dt_reg : s1_dq_reg;
        sw_s     = $signed({24'd0, cfg.seed_weight});
        m_c      = (dmin > sw_s) ? cfg.seed_weight : dmin[7:0];
    end

    // ---------------------------------------------------------------- stage 3
    logic [32:0]                 sum;
    logic [bac_pkg::SCORE_W-1:0] cand;
    logic                        improve, exceed, update;
    logic signed [SKW-1:0]       skips_inc, max_skips_s;

    always_comb
    begin
        sum         = {1'b0, s2_ps_reg} + {25'd0, s2_m_reg};
        cand        = !s2_link_reg ? '0 : (sum[32] ? '1 : sum[31:0]);
        improve     = cand > score_reg;
        skips_inc   = skips_reg + 1'b1;
        max_skips_s = $signed({{(SKW-8){1'b0}}, cfg.max_skips});
        exceed      = skips_inc > max_skips_s;
        update      = s2_v_reg && !s2_pass_reg && !s2_brk_reg;
        // The gap break ends the scan before any update; the last anchor ends it after.
        stop_now    = s2_v_reg && (s2_brk_reg || (update && !improve && exceed)
                                   || (s2_k_reg == lim_reg));
    end

    // ---------------------------------------------------------------- commit values
    logic [bac_pkg::COUNT_W-1:0] pred_full;
    logic [bac_pkg::SCORE_W-1:0] rb_new;
    logic                        end_c;

    always_comb
    begin
        pred_full = group_count_reg - bac_pkg::COUNT_W'(best_k_reg);
        rb_new    = (score_reg > running_best_reg) ? score_reg : running_best_reg;
        end_c     = (score_reg >= {16'd0, cfg.min_score})
                    && ({score_reg, 1'b0} > {1'b0, rb_new});
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bac_pkg::ST_IDLE;
            p0_v_reg         <= 1'b0;
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            lim_reg          <= '0;
            issue_cnt_reg    <= '0;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            fill_reg         <= '0;
            group_count_reg  <= '0;
            running_best_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p0_v_reg  <= issue;
            s1_v_reg  <= p0_v_reg && !stop_now;
            s2_v_reg  <= s1_v_reg && !stop_now;

            if (accept)
            begin
                lim_reg       <= lim_next;
                issue_cnt_reg <= '0;
                rd_ptr_reg    <= group_reset ? '0 : wr_ptr_reg;
                if (group_reset)
                begin
                    group_count_reg <= '0;
                    wr_ptr_reg      <= '0;
                    fill_reg        <= '0;
                end
                if (anchors.read_start)
                begin
                    running_best_reg <= '0;
                end
            end
            else if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
                rd_ptr_reg    <= raddr;
            end

            if (commit)
            begin
                wr_ptr_reg       <= (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
                running_best_reg <= rb_new;
                if (fill_reg != BAND_C)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (group_count_reg != '1)
                begin
                    group_count_reg <= group_count_reg + 1'b1;
                end
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        p0_k_reg    <= CW'(issue_cnt_reg + 1'b1);

        s1_pass_reg <= s1_eq || (!s1_brk_c && s1_neg);
        s1_brk_reg  <= !s1_eq && s1_brk_c;
        s1_dt_reg   <= s1_dt_c;
        s1_dq_reg   <= s1_dq_c;
        s1_ps_reg   <= rentry.score;
        s1_k_reg    <= p0_k_reg;

        s2_pass_reg <= s1_pass_reg;
        s2_brk_reg  <= s1_brk_reg;
        s2_link_reg <= link_c;
        s2_m_reg    <= m_c;
        s2_ps_reg   <= s1_ps_reg;
        s2_k_reg    <= s1_k_reg;

        if (accept)
        begin
            tq_reg     <= anchors.target_coord;
            qq_reg     <= anchors.query_coord;
            score_reg  <= {24'd0, cfg.seed_weight};
            best_k_reg <= '0;
            skips_reg  <= '0;
        end
        else if (update)
        begin
            if (improve)
            begin
                score_reg  <= cand;
                best_k_reg <= s2_k_reg;
                skips_reg  <= skips_reg - 1'b1;
            end
            else
            begin
                skips_reg <= skips_inc;
            end
        end

        if (commit)
        begin
            out_score_reg <= score_reg;
            out_pred_reg  <= pred_full[bac_pkg::INDEX_W-1:0];
            out_index_reg <= group_count_reg[bac_pkg::INDEX_W-1:0];
            out_end_reg   <= end_c;
            out_ovf_reg   <= group_count_reg >= bac_pkg::MAX_GROUP;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.chain_score       = out_score_reg;
    assign results.predecessor_index = out_pred_reg;
    assign results.group_index       = out_index_reg;
    assign results.end_candidate     = out_end_reg;
    assign results.overflow          = out_ovf_reg;

endmodule

// ===== bench/bac_chain_checker.sv =====
// Scoreboard for the banded anchor chaining core: watches the anchor, result and cfg channels.
// Predicts one result per anchor transfer and compares each result transfer against it.
// Depends on bac_pkg and the channel interfaces in bac_if.sv.
module bac_chain_checker
    import bac_pkg::*;
#(
    parameter int BAND = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    bac_anchor_if anchors,
    bac_result_if results,
    bac_cfg_if    cfg,
    output int    results_due,
    output int    mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SCORE_W-1:0] chain_score;
        logic [INDEX_W-1:0] predecessor_index;
        logic [INDEX_W-1:0] group_index;
        logic               end_candidate;
        logic               overflow;
    } chain_result_t;

    cfg_t                regs;
    logic [TARGET_W-1:0] win_target [BAND];
    logic [QUERY_W-1:0]  win_query  [BAND];
    logic [SCORE_W-1:0]  win_score  [BAND];
    logic [COUNT_W-1:0]  anchor_count;
    logic [SCORE_W-1:0]  read_best;
    int                  win_head;
    int                  win_fill;
    chain_result_t       pending_results [$];

    // Chains one anchor against the window of its group and advances the group state.
    function automatic chain_result_t chain_anchor(input logic [TARGET_W-1:0] t_in,
                                                   input logic [QUERY_W-1:0] q_in,
                                                   input logic gs_in, input logic rs_in);
        longint             cur_t, cur_q, prev_t, prev_q, dt, dq, gap, span;
        longint unsigned    linked;
        logic [SCORE_W-1:0] score, cand;
        logic [COUNT_W-1:0] idx, best_k;
        int                 lim, slot, skips;
        chain_result_t      r;
        cur_t = {33'd0, t_in};
        cur_q = {33'd0, q_in};
        if (rs_in)
            read_best = '0;
        if (gs_in || rs_in)
        begin
            anchor_count = '0;
            win_head = 0;
            win_fill = 0;
        end
        idx = anchor_count;
        score = {24'd0, regs.seed_weight};
        best_k = '0;
        skips = 0;
        lim = int'(regs.band_length);
        if (lim > BAND)
            lim = BAND;
        if (lim > win_fill)
            lim = win_fill;
        for (int k = 1; k <= lim; k++)
        begin
            slot = (win_head + BAND - k) % BAND;
            prev_t = {33'd0, win_target[slot]};
            prev_q = {33'd0, win_query[slot]};
            cand = '0;
            if (prev_q == cur_q || prev_t == cur_t)
                continue;
            if (prev_t + longint'({48'd0, regs.max_target_gap}) < cur_t)
                break;
            dt = cur_t - prev_t;
            dq = cur_q - prev_q;
            if (dq < 0)
                continue;
            gap = (dt > dq) ? dt - dq : dq - dt;
            // The slope window 0.75 < dq/dt < 5 is tested without division.
            if (gap < longint'({48'd0, regs.max_gap}) && dq < 5 * dt && 4 * dq > 3 * dt)
            begin
                span = (dt < dq) ? dt : dq;
                if (span > longint'({56'd0, regs.seed_weight}))
                    span = longint'({56'd0, regs.seed_weight});
                linked = {32'd0, win_score[slot]} + 64'(span);
                cand = (linked > 64'hFFFF_FFFF) ? '1 : 32'(linked);
            end
            if (cand > score)
            begin
                score = cand;
                best_k = k;
                skips--;
            end
            else
            begin
                skips++;
                if (skips > int'(regs.max_skips))
                    break;
            end
        end
        win_target[win_head] = t_in;
        win_query[win_head] = q_in;
        win_score[win_head] = score;
        win_head = (win_head + 1) % BAND;
        if (win_fill < BAND)
            win_fill++;
        if (score > read_best)
            read_best = score;
        r.chain_score = score;
        r.predecessor_index = INDEX_W'(idx - best_k);
        r.group_index = INDEX_W'(idx);
        r.end_candidate = (score >= {16'd0, regs.min_score}) &&
                          ({score, 1'b0} > {1'b0, read_best});
        r.overflow = (idx >= MAX_GROUP);
        if (anchor_count != '1)
            anchor_count++;
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        chain_result_t want;
        if (!rst_n)
        begin
            regs = '{SEED_WEIGHT_RST, MAX_GAP_RST, MAX_TARGET_GAP_RST, BAND_LENGTH_RST,
                     MAX_SKIPS_RST, MIN_SCORE_RST};
            for (int i = 0; i < BAND; i++)
            begin
                win_target[i] = '0;
                win_query[i] = '0;
                win_score[i] = '0;
            end
            anchor_count = '0;
            read_best = '0;
            win_head = 0;
            win_fill = 0;
            pending_results.delete();
            results_due = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_SEED_WEIGHT:    regs.seed_weight = cfg.data[7:0];
                    CFG_MAX_GAP:        regs.max_gap = cfg.data;
                    CFG_MAX_TARGET_GAP: regs.max_target_gap = cfg.data;
                    CFG_BAND_LENGTH:    regs.band_length = cfg.data[6:0];
                    CFG_MAX_SKIPS:      regs.max_skips = cfg.data[7:0];
                    CFG_MIN_SCORE:      regs.min_score = cfg.data;
                    default: ;
                endcase
            end
            if (results.valid && results.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no anchor outstanding, score %0d",
                           results.chain_score);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("chain_score", want.chain_score, results.chain_score);
                    check_field("predecessor_index", want.predecessor_index,
                                results.predecessor_index);
                    check_field("group_index", want.group_index, results.group_index);
                    check_field("end_candidate", want.end_candidate, results.end_candidate);
                    check_field("overflow", want.overflow, results.overflow);
                end
            end
            if (anchors.valid && anchors.ready)
                pending_results.insert(pending_results.size(),
                                       chain_anchor(anchors.target_coord,
                                                    anchors.query_coord,
                                                    anchors.group_start,
                                                    anchors.read_start));
            results_due = pending_results.size();
        end
    end

endmodule

// ===== bench/tb_banded_anchor_chaining_dp_core.sv =====
// Testbench top for the banded anchor chaining core: clock, reset, anchor and cfg stimulus,
// result back-pressure and the final verdict. Checking lives in bac_chain_checker.
// Depends on bac_pkg, bac_if.sv, the core and bench/bac_chain_checker.sv.
module tb_banded_anchor_chaining_dp_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bac_pkg::*;

    localparam int PHASES          = 8;
    localparam int CHUNK_ITEMS     = 36;
    localparam int IDLE_PCT        = 31;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 80;

    logic clk;
    logic rst_n;
    logic steady_flow;
    int   hold_requests;
    int   results_due;
    int   mismatch_count;
    cfg_t phase_regs;

    bac_anchor_if anchor_ch ();
    bac_result_if result_ch ();
    bac_cfg_if    cfg_ch ();

    banded_anchor_chaining_dp_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .anchors (anchor_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    bac_chain_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .anchors        (anchor_ch),
        .results        (result_ch),
        .cfg            (cfg_ch),
        .results_due    (results_due),
        .mismatch_count (mismatch_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result back-pressure; a requested hold-off keeps ready low for a counted stretch.
    initial
    begin
        int holds_served;
        holds_served = 0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                result_ch.ready <= 1'b0;
                for (int n = 1; n < HOLD_OFF_CYCLES; n++)
                    @(posedge clk);
                holds_served++;
            end
            else
                result_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_anchor(input logic [TARGET_W-1:0] t, input logic [QUERY_W-1:0] q,
                               input logic gs, input logic rs);
        int gap;
        gap = 0;
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
            gap++;
        if (gap > 0)
        begin
            anchor_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        anchor_ch.valid <= 1'b1;
        anchor_ch.target_coord <= t;
        anchor_ch.query_coord <= q;
        anchor_ch.group_start <= gs;
        anchor_ch.read_start <= rs;
        @(posedge clk);
        while (!anchor_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_all_results();
        anchor_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
        cfg_ch.index <= index;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s);
        cfg_ch.valid <= 1'b1;
        put_reg(CFG_SEED_WEIGHT, {8'd0, s.seed_weight});
        put_reg(CFG_MAX_GAP, s.max_gap);
        put_reg(CFG_MAX_TARGET_GAP, s.max_target_gap);
        put_reg(CFG_BAND_LENGTH, {9'd0, s.band_length});
        put_reg(CFG_MAX_SKIPS, {8'd0, s.max_skips});
        put_reg(CFG_MIN_SCORE, s.min_score);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic cfg_t phase_setting(input int p);
        cfg_t s;
        case (p)
            0: s = '{SEED_WEIGHT_RST, MAX_GAP_RST, MAX_TARGET_GAP_RST, BAND_LENGTH_RST,
                     MAX_SKIPS_RST, MIN_SCORE_RST};
            1: s = '{8'd255, 16'hFFFF, 16'hFFFF, 7'd127, 8'd255, 16'd0};
            2: s = '{8'd1, 16'd0, 16'd0, 7'd1, 8'd0, 16'hFFFF};
            3: s = '{8'd20, 16'd100, 16'd300, 7'd0, 8'd3, 16'd40};
            4: s = '{8'd15, 16'd1000, 16'd2000, 7'd64, 8'd2, 16'd30};
            5: s = '{8'd16, 16'd40, 16'd120, 7'd65, 8'd1, 16'd50};
            default:
            begin
                s.seed_weight = 8'($urandom_range(1, 255));
                s.max_gap = 16'($urandom_range(0, 1500));
                s.max_target_gap = 16'($urandom_range(0, 6000));
                s.band_length = 7'($urandom_range(1, 64));
                s.max_skips = 8'($urandom_range(0, 40));
                s.min_score = 16'($urandom_range(0, 300));
            end
        endcase
        return s;
    endfunction

    // Mostly sorted groups that chain well, with gaps, repeats and reversals mixed in.
    task automatic run_random(input int count);
        int                  sent, len, kind, dt;
        logic [TARGET_W-1:0] t;
        logic [QUERY_W-1:0]  q;
        logic                gs, rs;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                  : $urandom_range(1, 24);
                t = 31'($urandom_range(0, 32'h7FF0_0000));
                q = 31'($urandom_range(0, 32'h7FF0_0000));
                gs = ($urandom_range(0, 9) != 0);
                rs = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < len && sent < count; i++)
                begin
                    send_anchor(t, q, gs, rs);
                    sent++;
                    gs = 1'b0;
                    rs = 1'b0;
                    kind = $urandom_range(0, 99);
                    dt = $urandom_range(1, 40);
                    if (kind < 70)
                    begin
                        t = t + 31'(dt);
                        q = q + 31'($urandom_range((dt * 3) / 4, dt * 2 + 2));
                    end
                    else if (kind < 78)
                        q = q + 31'($urandom_range(0, 20));
                    else if (kind < 84)
                        t = t + 31'(dt);
                    else if (kind < 90)
                    begin
                        t = t + 31'(dt);
                        q = q - 31'($urandom_range(1, 50));
                    end
                    else if (kind < 95)
                    begin
                        t = t + 31'(phase_regs.max_target_gap) + 31'($urandom_range(1, 200));
                        q = q + 31'($urandom_range(0, 400));
                    end
                    else
                    begin
                        t = t + 31'(dt);
                        q = q + 31'($urandom_range(dt * 5, dt * 8));
                    end
                end
            end
            else
            begin
                send_anchor(31'($urandom), 31'($urandom), $urandom_range(0, 3) == 0,
                            $urandom_range(0, 7) == 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        anchor_ch.valid <= 1'b0;
        anchor_ch.target_coord <= '0;
        anchor_ch.query_coord <= '0;
        anchor_ch.group_start <= 1'b0;
        anchor_ch.read_start <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_SEED_WEIGHT;
        cfg_ch.data <= '0;
        steady_flow = 1'b0;
        hold_requests = 0;
        phase_regs = phase_setting(0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first anchor carries no group start and opens the empty group.
        send_anchor(31'd100, 31'd100, 1'b0, 1'b0);
        send_anchor(31'd110, 31'd110, 1'b0, 1'b0);
        send_anchor(31'd120, 31'd118, 1'b0, 1'b0);
        // Equal query, then equal target, then a query that moves backward.
        send_anchor(31'd125, 31'd118, 1'b0, 1'b0);
        send_anchor(31'd125, 31'd130, 1'b0, 1'b0);
        send_anchor(31'd140, 31'd120, 1'b0, 1'b0);
        // A target that moves backward fails the slope test.
        send_anchor(31'd90, 31'd200, 1'b0, 1'b0);
        // Far beyond the target gap limit, then a slope that is too steep.
        send_anchor(31'd9000, 31'd9000, 1'b0, 1'b0);
        send_anchor(31'd9010, 31'd9100, 1'b0, 1'b0);
        send_anchor(31'd9020, 31'd9015, 1'b0, 1'b0);
        send_anchor(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b1);
        send_anchor(31'd0, 31'd0, 1'b1, 1'b0);
        send_anchor(31'h7FFF_FFFF, 31'd0, 1'b0, 1'b0);
        send_anchor(31'd0, 31'h7FFF_FFFF, 1'b0, 1'b0);
        // A clean chain that climbs past the end-candidate threshold.
        send_anchor(31'd5, 31'd4, 1'b1, 1'b1);
        send_anchor(31'd10, 31'd9, 1'b0, 1'b0);
        send_anchor(31'd15, 31'd14, 1'b0, 1'b0);
        send_anchor(31'd20, 31'd19, 1'b0, 1'b0);
        send_anchor(31'd25, 31'd24, 1'b0, 1'b0);
        send_anchor(31'd26, 31'd40, 1'b0, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_all_results();
            repeat (SETTLE_CYCLES) @(posedge clk);
            phase_regs = phase_setting(p);
            load_settings(phase_regs);
            steady_flow = (p == 0);
            run_random(CHUNK_ITEMS);
            steady_flow = 1'b0;
            if (p == 0 || p == 4)
                hold_requests++;
            else if (p == 2)
                wait_all_results();
            run_random(CHUNK_ITEMS);
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
